@@ hw/rtl/pfmq_pkg.sv @@
// ----------------------------------------------------------------------------
// pfmq_pkg
// Shared types and field widths of the per-flow message queue.
// ----------------------------------------------------------------------------
package pfmq_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 3'd0,
    OP_PEEK      = 3'd1,
    OP_POP       = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_CLEAR_ALL = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_Q_FULL   = 2'd2,
    STAT_TBL_FULL = 2'd3
  } status_e;

  // Flow table update command
  typedef enum logic [1:0] {
    UPD_NONE     = 2'd0,
    UPD_WRITE    = 2'd1,
    UPD_FREE     = 2'd2,
    UPD_FREE_ALL = 2'd3
  } upd_e;

  // Lookup status toward the control FSM
  typedef struct packed {
    logic done;
    logic found;
    logic free_ok;
  } lk_res_t;

endpackage

@@ hw/rtl/pfmq_ram.sv @@
// ----------------------------------------------------------------------------
// pfmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfmq_ram #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pfmq_lookup.sv @@
// ----------------------------------------------------------------------------
// pfmq_lookup
// Flow table: keys and queue pointers in a RAM, valid bits in flops.
// Scans the slots one read per cycle to match a key and find the lowest free
// slot; applies table updates from the control FSM.
// ----------------------------------------------------------------------------
module pfmq_lookup #(
  parameter int unsigned NUM_FLOWS = 16,
  parameter int unsigned ENT_W     = 44
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pfmq_pkg::KEY_W-1:0]   key_i,
  output pfmq_pkg::lk_res_t            res_o,
  output logic [$clog2(NUM_FLOWS)-1:0] slot_o,
  output logic [$clog2(NUM_FLOWS)-1:0] free_slot_o,
  output logic [ENT_W-1:0]             entry_o,
  input  pfmq_pkg::upd_e               upd_i,
  input  logic [$clog2(NUM_FLOWS)-1:0] upd_slot_i,
  input  logic [ENT_W-1:0]             upd_entry_i
);

  localparam int unsigned SW = $clog2(NUM_FLOWS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_FLOWS - 1);

  logic [NUM_FLOWS-1:0]          valid_q;
  logic                          issue_q;
  logic [SW-1:0]                 rd_idx_q;
  logic                          chk_vld_q;
  logic [SW-1:0]                 chk_idx_q;
  logic                          chk_last_q;
  logic                          done_q;
  logic                          found_q;
  logic                          free_ok_q;
  logic [pfmq_pkg::KEY_W-1:0]    key_q;
  logic [SW-1:0]                 slot_q;
  logic [SW-1:0]                 free_q;
  logic [ENT_W-1:0]              entry_q;
  logic [ENT_W-1:0]              rd_data;
  logic                          rd_last;
  logic                          hit;
  logic                          take_free;

  pfmq_ram #(
    .DW    (ENT_W),
    .DEPTH (NUM_FLOWS)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (upd_i == pfmq_pkg::UPD_WRITE),
    .waddr_i (upd_slot_i),
    .wdata_i (upd_entry_i),
    .re_i    (issue_q),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  assign rd_last   = (rd_idx_q == LAST_SLOT);
  assign hit       = chk_vld_q && !done_q && valid_q[chk_idx_q]
                     && (rd_data[pfmq_pkg::KEY_W-1:0] == key_q);
  assign take_free = chk_vld_q && !done_q && !valid_q[chk_idx_q] && !free_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      issue_q    <= 1'b0;
      rd_idx_q   <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      chk_last_q <= 1'b0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      free_ok_q  <= 1'b0;
    end else begin
      unique case (upd_i)
        pfmq_pkg::UPD_NONE:     ;
        pfmq_pkg::UPD_WRITE:    valid_q[upd_slot_i] <= 1'b1;
        pfmq_pkg::UPD_FREE:     valid_q[upd_slot_i] <= 1'b0;
        pfmq_pkg::UPD_FREE_ALL: valid_q <= '0;
      endcase
      if (start_i) begin
        issue_q   <= 1'b1;
        rd_idx_q  <= '0;
        chk_vld_q <= 1'b0;
        done_q    <= 1'b0;
        found_q   <= 1'b0;
        free_ok_q <= 1'b0;
      end else begin
        chk_vld_q  <= issue_q;
        chk_idx_q  <= rd_idx_q;
        chk_last_q <= rd_last;
        if (issue_q) begin
          rd_idx_q <= rd_idx_q + 1'b1;
          if (rd_last) begin
            issue_q <= 1'b0;
          end
        end
        if (take_free) begin
          free_ok_q <= 1'b1;
        end
        if (chk_vld_q && !done_q && chk_last_q) begin
          done_q <= 1'b1;
        end
        // stop the scan on the first match and drop the read in flight
        if (hit) begin
          found_q   <= 1'b1;
          done_q    <= 1'b1;
          issue_q   <= 1'b0;
          chk_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (hit) begin
      slot_q  <= chk_idx_q;
      entry_q <= rd_data;
    end
    if (take_free) begin
      free_q <= chk_idx_q;
    end
  end

  assign res_o.done    = done_q;
  assign res_o.found   = found_q;
  assign res_o.free_ok = free_ok_q;
  assign slot_o        = slot_q;
  assign free_slot_o   = free_q;
  assign entry_o       = entry_q;

endmodule

@@ hw/rtl/per_flow_message_queue_top.sv @@
// ----------------------------------------------------------------------------
// per_flow_message_queue_top
// Per-flow FIFOs of message handles, keyed by a 31-bit connection key.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+----------------------------------
//  s_axis   | in  | tvalid_i / tready_o    | tuser: operation; tdata: key, handle
//  m_axis   | out | tvalid_o / tready_i    | tdata: status, has, front, count
//
//  Order: one item at a time. A flow-table scan reads one slot per cycle and
//  stops on the first key match, so its length depends on the matching slot;
//  peek and pop add a message store read (ST_READ) before the result.
//  Reset: valid bits of the flow table clear at once; no clearing pass.
//  Stalls: the result register frees the input side, so the next beat is
//  taken while a result waits; a full result register holds the FSM in DONE.
//
module per_flow_message_queue_top #(
  parameter int unsigned NUM_FLOWS   = 16,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [30:0] flow_key, [46:31] msg_handle, [47] zero
  input  logic [47:0] s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [2] has_message, [18:3] front_handle, [23:19] queued_count
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned KEY_W     = pfmq_pkg::KEY_W;
  localparam int unsigned HANDLE_W  = pfmq_pkg::HANDLE_W;
  localparam int unsigned CNT_OUT_W = pfmq_pkg::COUNT_W;
  localparam int unsigned SW        = $clog2(NUM_FLOWS);
  localparam int unsigned IW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W     = KEY_W + 2 * IW + CW;
  localparam int unsigned MSG_DEPTH = NUM_FLOWS * QUEUE_DEPTH;
  localparam int unsigned AW        = $clog2(MSG_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_e;

  state_e                  state_q;
  pfmq_pkg::op_e           op_q;
  // Key of the held beat; for a matched flow it equals the stored key.
  logic [KEY_W-1:0]        key_q;
  logic [HANDLE_W-1:0]     handle_q;
  pfmq_pkg::status_e       status_q;
  logic                    has_q;
  logic [HANDLE_W-1:0]     front_q;
  logic [CW-1:0]           cnt_q;
  logic                    m_valid_q;
  logic [23:0]             m_data_q;

  logic                    accept;
  logic                    out_load;
  pfmq_pkg::lk_res_t       lk_res;
  logic [SW-1:0]           lk_slot;
  logic [SW-1:0]           lk_free;
  logic [ENT_W-1:0]        lk_entry;

  pfmq_pkg::upd_e          upd;
  logic [SW-1:0]           upd_slot;
  logic [ENT_W-1:0]        upd_entry;

  logic                    st_we;
  logic [AW-1:0]           st_waddr;
  logic                    st_re;
  logic [AW-1:0]           st_raddr;
  logic [HANDLE_W-1:0]     st_rdata;

  logic [KEY_W-1:0]        e_key;
  logic [IW-1:0]           e_head;
  logic [IW-1:0]           e_tail;
  logic [CW-1:0]           e_cnt;
  logic                    had;
  logic [SW-1:0]           a_slot;
  logic [IW-1:0]           a_head;
  logic [IW-1:0]           a_tail;
  logic [CW-1:0]           a_cnt;
  logic [IW-1:0]           tail_nxt;
  logic [IW-1:0]           head_nxt;
  pfmq_pkg::status_e       nxt_status;
  logic [CW-1:0]           nxt_cnt;
  logic                    go_read;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // Load the result register in DONE once it is empty or being drained
  assign out_load        = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  pfmq_lookup #(
    .NUM_FLOWS (NUM_FLOWS),
    .ENT_W     (ENT_W)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .key_i       (s_axis_tdata_i[KEY_W-1:0]),
    .res_o       (lk_res),
    .slot_o      (lk_slot),
    .free_slot_o (lk_free),
    .entry_o     (lk_entry),
    .upd_i       (upd),
    .upd_slot_i  (upd_slot),
    .upd_entry_i (upd_entry)
  );

  pfmq_ram #(
    .DW    (HANDLE_W),
    .DEPTH (MSG_DEPTH)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (handle_q),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Unpack the matched flow entry: {count, tail, head, key}
  assign e_key  = lk_entry[KEY_W-1:0];
  assign e_head = lk_entry[KEY_W +: IW];
  assign e_tail = lk_entry[KEY_W + IW +: IW];
  assign e_cnt  = lk_entry[KEY_W + 2 * IW +: CW];
  assign had    = lk_res.found && (e_cnt != '0);

  // An add to a new key starts from an empty queue in the lowest free slot
  assign a_slot   = lk_res.found ? lk_slot : lk_free;
  assign a_head   = lk_res.found ? e_head : '0;
  assign a_tail   = lk_res.found ? e_tail : '0;
  assign a_cnt    = lk_res.found ? e_cnt : '0;
  assign tail_nxt = (a_tail == LAST_IDX) ? '0 : a_tail + 1'b1;
  assign head_nxt = (e_head == LAST_IDX) ? '0 : e_head + 1'b1;

  // Message store address: slot base plus queue index
  assign st_waddr = AW'(AW'(a_slot) * AW'(QUEUE_DEPTH)) + AW'(a_tail);
  assign st_raddr = AW'(AW'(lk_slot) * AW'(QUEUE_DEPTH)) + AW'(e_head);

  always_comb begin
    nxt_status = pfmq_pkg::STAT_OK;
    nxt_cnt    = lk_res.found ? e_cnt : '0;
    upd        = pfmq_pkg::UPD_NONE;
    upd_slot   = lk_slot;
    upd_entry  = lk_entry;
    st_we      = 1'b0;
    st_re      = 1'b0;
    go_read    = 1'b0;
    if (state_q == ST_EXEC) begin
      unique case (op_q)
        pfmq_pkg::OP_ADD: begin
          if (!lk_res.found && !lk_res.free_ok) begin
            nxt_status = pfmq_pkg::STAT_TBL_FULL;
            nxt_cnt    = '0;
          end else if (a_cnt == FULL_CNT) begin
            nxt_status = pfmq_pkg::STAT_Q_FULL;
            nxt_cnt    = a_cnt;
          end else begin
            nxt_cnt   = a_cnt + 1'b1;
            st_we     = 1'b1;
            upd       = pfmq_pkg::UPD_WRITE;
            upd_slot  = a_slot;
            upd_entry = {a_cnt + 1'b1, tail_nxt, a_head, key_q};
          end
        end
        pfmq_pkg::OP_PEEK,
        pfmq_pkg::OP_POP: begin
          if (!had) begin
            nxt_status = pfmq_pkg::STAT_EMPTY;
          end else begin
            st_re   = 1'b1;
            go_read = 1'b1;
            if (op_q == pfmq_pkg::OP_POP) begin
              nxt_cnt = e_cnt - 1'b1;
              // drop the slot when the last message leaves
              if (e_cnt == CW'(1)) begin
                upd = pfmq_pkg::UPD_FREE;
              end else begin
                upd       = pfmq_pkg::UPD_WRITE;
                upd_entry = {e_cnt - 1'b1, e_tail, head_nxt, e_key};
              end
            end
          end
        end
        pfmq_pkg::OP_CLEAR: begin
          nxt_cnt = '0;
          if (lk_res.found) begin
            upd = pfmq_pkg::UPD_FREE;
          end else begin
            nxt_status = pfmq_pkg::STAT_EMPTY;
          end
        end
        pfmq_pkg::OP_CLEAR_ALL: begin
          nxt_cnt = '0;
          upd     = pfmq_pkg::UPD_FREE_ALL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= pfmq_pkg::OP_ADD;
      key_q     <= '0;
      handle_q  <= '0;
      status_q  <= pfmq_pkg::STAT_OK;
      has_q     <= 1'b0;
      front_q   <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {CNT_OUT_W'(cnt_q), front_q, has_q, status_q};
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= pfmq_pkg::op_e'(s_axis_tuser_i);
            key_q    <= s_axis_tdata_i[KEY_W-1:0];
            handle_q <= s_axis_tdata_i[KEY_W +: HANDLE_W];
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (lk_res.done) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          status_q <= nxt_status;
          has_q    <= had;
          front_q  <= '0;
          cnt_q    <= nxt_cnt;
          state_q  <= go_read ? ST_READ : ST_DONE;
        end
        ST_READ: begin
          front_q <= st_rdata;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTH
  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !lk_res.done)
    else $error("lookup done not cleared by a new item");

  a_no_store_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && st_re))
    else $error("message store written and read by one item");

  a_write_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd == pfmq_pkg::UPD_WRITE) |-> (upd_entry[KEY_W + 2 * IW +: CW] != '0))
    else $error("flow entry written with an empty queue");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
